// ===== rtl/two_class_fifo_queue_macros.svh =====
// two_class_fifo_queue_macros.svh: assertion macros for the two-class queue checker
// depends on: nothing; expects clk and rst_n in the scope of use
`ifndef TWO_CLASS_FIFO_QUEUE_MACROS_SVH
`define TWO_CLASS_FIFO_QUEUE_MACROS_SVH

// property checked only outside reset
`define TCFQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define TCFQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/tcfq_pkg.sv =====
// tcfq_pkg.sv: operation and status codes and the result type of the two-class queue
// depends on: nothing
`timescale 1ns / 1ps

package tcfq_pkg;

    // payload widths fixed by the channel definition
    localparam int IdW = 16;

    // operation codes
    localparam logic [1:0] OP_ENQUEUE   = 2'd0;
    localparam logic [1:0] OP_DEQ_ANY   = 2'd1;
    localparam logic [1:0] OP_DEQ_CLASS = 2'd2;
    localparam logic [1:0] OP_UNUSED    = 2'd3;

    // status codes
    localparam logic [1:0] ST_SERVED   = 2'd0;
    localparam logic [1:0] ST_NONE     = 2'd1;
    localparam logic [1:0] ST_ENQUEUED = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // one result item
    typedef struct packed {
        logic [1:0]     status;
        logic [IdW-1:0] served_id;
        logic           served_class;
    } res_t;

endpackage

// ===== rtl/tcfq_if.sv =====
// tcfq_if.sv: valid/ready channels for operation items and result items
// depends on: tcfq_pkg
`timescale 1ns / 1ps

// operation channel
interface tcfq_op_if
    import tcfq_pkg::*;
();
    logic           valid;
    logic           ready;
    logic [1:0]     operation;
    logic           entry_class;
    logic [IdW-1:0] entry_id;

    modport source (output valid, output operation, output entry_class, output entry_id,
                    input ready);
    modport sink (input valid, input operation, input entry_class, input entry_id,
                  output ready);
    modport monitor (input valid, input ready, input operation, input entry_class,
                     input entry_id);
endinterface

// result channel
interface tcfq_res_if
    import tcfq_pkg::*;
();
    logic           valid;
    logic           ready;
    logic [1:0]     status;
    logic [IdW-1:0] served_id;
    logic           served_class;

    modport source (output valid, output status, output served_id, output served_class,
                    input ready);
    modport sink (input valid, input status, input served_id, input served_class,
                  output ready);
    modport monitor (input valid, input ready, input status, input served_id,
                     input served_class);
endinterface

// ===== rtl/two_class_fifo_queue.sv =====
// Two-class queue of tagged entries: op_in takes operations, res_out gives one result
// item per operation (valid/ready on both). Enqueue appends (id, class) unless DEPTH
// entries are held in total; dequeue-any removes the oldest entry of either class;
// dequeue-class removes the oldest entry of the given class.
// Storage is one circular buffer per class; each entry carries an arrival stamp that
// counts modulo 2*DEPTH, and the older of the two class heads is found by stamp age.
// Throughput: one item per cycle while op_in.ready is high. Each result is registered
// in the result buffer and reaches res_out behind any earlier results. The head-entry
// register of each class buffer, reloaded from the buffer memory in the same cycle as
// a pop or push, keeps the rate at one item per cycle while op_in.ready is high.
// A two-entry result buffer sits before res_out: while the receiver stalls, one more
// item is still taken; op_in.ready falls once both entries are held.
// Reset (rst_n low, asynchronous) empties both class buffers, the result buffer and
// the stamp counter; no clearing pass is needed, so items are taken right after reset.
// Stored entries are never served before they are written.
`timescale 1ns / 1ps

module two_class_fifo_queue
    import tcfq_pkg::*;
#(
    parameter int DEPTH   = 16,
    parameter int ID_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    tcfq_op_if.sink    op_in,
    tcfq_res_if.source res_out
);

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int STAMP_W = $clog2(2 * DEPTH);
    localparam int ENTRY_W = ID_BITS + STAMP_W;

    localparam logic [PTR_W-1:0]   PTR_LAST   = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W:0]     TOTAL_MAX  = (CNT_W + 1)'(DEPTH);
    localparam logic [STAMP_W:0]   STAMP_MOD  = (STAMP_W + 1)'(2 * DEPTH);
    localparam logic [STAMP_W-1:0] STAMP_LAST = STAMP_W'(2 * DEPTH - 1);
    localparam logic [1:0]         OBUF_FULL  = 2'd2;

    // per-class pointers, counts and head entries
    logic [PTR_W-1:0]   head_reg      [2];
    logic [PTR_W-1:0]   head_next     [2];
    logic [PTR_W-1:0]   tail_reg      [2];
    logic [PTR_W-1:0]   tail_next     [2];
    logic [CNT_W-1:0]   count_reg     [2];
    logic [CNT_W-1:0]   count_next    [2];
    logic [ENTRY_W-1:0] head_data_reg [2];
    logic [STAMP_W:0]   age           [2];
    logic               not_empty     [2];
    logic               push          [2];
    logic               pop           [2];

    logic [STAMP_W-1:0] arrival_reg;
    logic [STAMP_W-1:0] arrival_next;

    logic               accept;
    logic               do_push;
    logic               do_pop;
    logic               pop_sel;
    logic [CNT_W:0]     total;
    logic [ID_BITS+IdW-1:0] in_ext;
    logic [ID_BITS+IdW-1:0] out_ext;
    logic [ENTRY_W-1:0] new_entry;
    res_t               res_new;

    // result buffer
    res_t               slot_reg  [2];
    res_t               slot_next [2];
    logic [1:0]         ocount_reg;
    logic [1:0]         ocount_next;
    logic               res_pop;

    assign accept  = op_in.valid && op_in.ready;
    assign res_pop = res_out.valid && res_out.ready;

    // new entry: low id bits and the current stamp
    assign in_ext    = {{ID_BITS{1'b0}}, op_in.entry_id};
    assign new_entry = {arrival_reg, in_ext[ID_BITS-1:0]};
    assign total     = {1'b0, count_reg[0]} + {1'b0, count_reg[1]};

    // age of each class head, modulo twice the depth
    always_comb
    begin
        for (int c = 0; c < 2; c++)
        begin
            not_empty[c] = (count_reg[c] != '0);
            if (arrival_reg >= head_data_reg[c][ENTRY_W-1:ID_BITS])
            begin
                age[c] = {1'b0, arrival_reg} - {1'b0, head_data_reg[c][ENTRY_W-1:ID_BITS]};
            end
            else
            begin
                age[c] = {1'b0, arrival_reg} + STAMP_MOD
                         - {1'b0, head_data_reg[c][ENTRY_W-1:ID_BITS]};
            end
        end
    end

    // operation decode and result
    always_comb
    begin
        do_push = 1'b0;
        do_pop  = 1'b0;
        pop_sel = 1'b0;
        res_new = '{status: ST_NONE, served_id: '0, served_class: 1'b0};
        unique case (op_in.operation)
            OP_ENQUEUE:
            begin
                if (total >= TOTAL_MAX)
                begin
                    res_new.status = ST_FULL;
                end
                else
                begin
                    do_push        = 1'b1;
                    res_new.status = ST_ENQUEUED;
                end
            end
            OP_DEQ_ANY:
            begin
                do_pop  = not_empty[0] || not_empty[1];
                pop_sel = not_empty[1] && (!not_empty[0] || (age[0] < age[1]));
            end
            OP_DEQ_CLASS:
            begin
                pop_sel = op_in.entry_class;
                do_pop  = not_empty[op_in.entry_class];
            end
            default:
            begin
                do_pop = 1'b0;
            end
        endcase
        if (do_pop)
        begin
            res_new.status       = ST_SERVED;
            res_new.served_id    = out_ext[IdW-1:0];
            res_new.served_class = pop_sel;
        end
    end

    assign out_ext = {{IdW{1'b0}}, head_data_reg[pop_sel][ID_BITS-1:0]};

    // stamp counter
    always_comb
    begin
        arrival_next = arrival_reg;
        if (accept && do_push)
        begin
            arrival_next = (arrival_reg == STAMP_LAST) ? '0 : arrival_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arrival_reg <= '0;
        end
        else
        begin
            arrival_reg <= arrival_next;
        end
    end

    // one circular buffer per class
    for (genvar c = 0; c < 2; c++)
    begin : g_class
        logic [ENTRY_W-1:0] store_mem [DEPTH];

        assign push[c] = accept && do_push && (op_in.entry_class == 1'(c));
        assign pop[c]  = accept && do_pop && (pop_sel == 1'(c));

        // pointer and count update
        always_comb
        begin
            head_next[c]  = head_reg[c];
            tail_next[c]  = tail_reg[c];
            count_next[c] = count_reg[c];
            if (pop[c])
            begin
                head_next[c]  = (head_reg[c] == PTR_LAST) ? '0 : head_reg[c] + 1'b1;
                count_next[c] = count_reg[c] - 1'b1;
            end
            if (push[c])
            begin
                tail_next[c]  = (tail_reg[c] == PTR_LAST) ? '0 : tail_reg[c] + 1'b1;
                count_next[c] = count_reg[c] + 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                head_reg[c]  <= '0;
                tail_reg[c]  <= '0;
                count_reg[c] <= '0;
            end
            else
            begin
                head_reg[c]  <= head_next[c];
                tail_reg[c]  <= tail_next[c];
                count_reg[c] <= count_next[c];
            end
        end

        // entry write at the tail
        always_ff @(posedge clk)
        begin
            if (push[c])
            begin
                store_mem[tail_reg[c]] <= new_entry;
            end
        end

        // head entry read, with bypass when the head is written in the same cycle
        always_ff @(posedge clk)
        begin
            if (push[c] && (tail_reg[c] == head_next[c]))
            begin
                head_data_reg[c] <= new_entry;
            end
            else
            begin
                head_data_reg[c] <= store_mem[head_next[c]];
            end
        end
    end

    // two-entry result buffer
    always_comb
    begin
        slot_next[0] = slot_reg[0];
        slot_next[1] = slot_reg[1];
        ocount_next  = ocount_reg;
        if (res_pop && !accept)
        begin
            slot_next[0] = slot_reg[1];
            ocount_next  = ocount_reg - 1'b1;
        end
        else if (accept && !res_pop)
        begin
            if (ocount_reg == '0)
            begin
                slot_next[0] = res_new;
            end
            else
            begin
                slot_next[1] = res_new;
            end
            ocount_next = ocount_reg + 1'b1;
        end
        else if (accept && res_pop)
        begin
            if (ocount_reg == OBUF_FULL)
            begin
                slot_next[0] = slot_reg[1];
                slot_next[1] = res_new;
            end
            else
            begin
                slot_next[0] = res_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ocount_reg <= '0;
        end
        else
        begin
            ocount_reg <= ocount_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg[0] <= slot_next[0];
        slot_reg[1] <= slot_next[1];
    end

    // channel outputs
    assign op_in.ready          = (ocount_reg != OBUF_FULL);
    assign res_out.valid        = (ocount_reg != '0);
    assign res_out.status       = slot_reg[0].status;
    assign res_out.served_id    = slot_reg[0].served_id;
    assign res_out.served_class = slot_reg[0].served_class;

endmodule

// ===== rtl/tcfq_checker.sv =====
// tcfq_checker.sv: port-level assertions for the two-class queue, bound to the top level
// depends on: tcfq_pkg, two_class_fifo_queue, two_class_fifo_queue_macros.svh
`timescale 1ns / 1ps
`include "two_class_fifo_queue_macros.svh"

module tcfq_sva
    import tcfq_pkg::*;
(
    input logic           clk,
    input logic           rst_n,
    input logic           op_valid,
    input logic           op_ready,
    input logic [1:0]     op_operation,
    input logic           res_valid,
    input logic           res_ready,
    input logic [1:0]     res_status,
    input logic [IdW-1:0] res_served_id,
    input logic           res_served_class
);

    // no result item shown at the edge after a reset edge
    `TCFQ_ASSERT_ALWAYS(a_no_valid_in_reset, !rst_n |=> !res_valid, "result valid in reset")

    // a stalled result holds its payload
    `TCFQ_ASSERT(a_res_hold,
        res_valid && !res_ready |=> res_valid && $stable(res_status)
            && $stable(res_served_id) && $stable(res_served_class),
        "stalled result changed")

    // an empty result side never blocks an operation
    `TCFQ_ASSERT(a_ready_when_empty, !res_valid |-> op_ready, "operation blocked, none pending")

    // an item taken with no result pending shows its result in the next cycle
    `TCFQ_ASSERT(a_one_cycle_latency,
        op_valid && op_ready && !res_valid |=> res_valid,
        "result missing one cycle after item")

    // the unused operation code answers none available
    `TCFQ_ASSERT(a_unused_op,
        op_valid && op_ready && !res_valid && op_operation == OP_UNUSED
            |=> res_status == ST_NONE && res_served_id == '0 && !res_served_class,
        "unused operation not answered as none")

endmodule

bind two_class_fifo_queue tcfq_sva u_tcfq_sva (
    .clk              (clk),
    .rst_n            (rst_n),
    .op_valid         (op_in.valid),
    .op_ready         (op_in.ready),
    .op_operation     (op_in.operation),
    .res_valid        (res_out.valid),
    .res_ready        (res_out.ready),
    .res_status       (res_out.status),
    .res_served_id    (res_out.served_id),
    .res_served_class (res_out.served_class)
);

// ===== tb/sv/tcfq_checker.sv =====
// tcfq_checker.sv: watches both channels of the two-class queue, predicts each result
// and compares it with the result item that comes out
// depends on: tcfq_pkg, tcfq_if
`timescale 1ns / 1ps

module tcfq_checker
    import tcfq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    tcfq_op_if.monitor  op_mon,
    tcfq_res_if.monitor res_mon,
    output int          mismatches,
    output int          awaited
);

    // one held entry of the queue
    typedef struct packed {
        logic [IdW-1:0] id;
        logic           cls;
        int             stamp;
    } entry_t;

    // held entries in arrival order, oldest first
    entry_t held_entries[$];
    // results still owed by the block, oldest first
    res_t   owed_results[$];
    // stamp for the next enqueued entry, modulo twice the depth
    int     stamp_ctr;

    // apply one operation to the held entries and return its result
    function automatic res_t serve_operation(input logic [1:0] op, input logic cls,
                                             input logic [IdW-1:0] id);
        res_t   r;
        entry_t e;
        int     pick;
        int     front0;
        int     front1;
        int     age0;
        int     age1;
        int     i;
        r.status       = ST_NONE;
        r.served_id    = '0;
        r.served_class = 1'b0;
        pick           = -1;
        front0         = -1;
        front1         = -1;
        case (op)
            OP_ENQUEUE:
            begin
                if (held_entries.size() >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    e.id    = id;
                    e.cls   = cls;
                    e.stamp = stamp_ctr;
                    held_entries.push_back(e);
                    stamp_ctr = (stamp_ctr + 1) % (2 * DEPTH);
                    r.status  = ST_ENQUEUED;
                end
            end
            OP_DEQ_ANY:
            begin
                // front entry of each class; the larger wrapped stamp age wins,
                // a tie goes to the first class
                for (i = 0; i < held_entries.size(); i++)
                begin
                    if (front0 < 0 && held_entries[i].cls == 1'b0)
                        front0 = i;
                    if (front1 < 0 && held_entries[i].cls == 1'b1)
                        front1 = i;
                end
                if (front0 >= 0 && front1 >= 0)
                begin
                    age0 = (stamp_ctr + 2 * DEPTH - held_entries[front0].stamp) % (2 * DEPTH);
                    age1 = (stamp_ctr + 2 * DEPTH - held_entries[front1].stamp) % (2 * DEPTH);
                    pick = (age0 >= age1) ? front0 : front1;
                end
                else if (front0 >= 0)
                    pick = front0;
                else
                    pick = front1;
            end
            OP_DEQ_CLASS:
            begin
                // oldest entry of the requested class
                for (i = 0; i < held_entries.size() && pick < 0; i++)
                    if (held_entries[i].cls == cls)
                        pick = i;
            end
            default:
            begin
                // unused code: nothing changes
            end
        endcase
        if (pick >= 0)
        begin
            r.status       = ST_SERVED;
            r.served_id    = held_entries[pick].id;
            r.served_class = held_entries[pick].cls;
            held_entries.delete(pick);
        end
        return r;
    endfunction

    // count a failure, report only the first few
    task automatic log_mismatch(input string what, input res_t want, input res_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected %0d/%h/%0d, got %0d/%h/%0d (status/id/class)",
                     $realtime, what, want.status, want.served_id, want.served_class,
                     got.status, got.served_id, got.served_class);
    endtask

    // result side first: a result never belongs to an item taken at the same edge
    always @(posedge clk or negedge rst_n)
    begin
        res_t got;
        res_t want;
        if (!rst_n)
        begin
            held_entries.delete();
            owed_results.delete();
            stamp_ctr  = 0;
            mismatches = 0;
            awaited    = 0;
        end
        else
        begin
            if (res_mon.valid && res_mon.ready)
            begin
                got.status       = res_mon.status;
                got.served_id    = res_mon.served_id;
                got.served_class = res_mon.served_class;
                if (owed_results.size() == 0)
                    log_mismatch("result item with none expected", '0, got);
                else
                begin
                    want = owed_results.pop_front();
                    if (got.status !== want.status || got.served_id !== want.served_id
                        || got.served_class !== want.served_class)
                        log_mismatch("result mismatch", want, got);
                end
            end
            if (op_mon.valid && op_mon.ready)
                owed_results.push_back(serve_operation(op_mon.operation, op_mon.entry_class,
                                                       op_mon.entry_id));
            awaited = owed_results.size();
        end
    end

endmodule

// ===== tb/sv/tb_two_class_fifo_queue.sv =====
// tb_two_class_fifo_queue.sv: top of the two-class queue testbench; drives operation
// items and receiver stalls, and gives the verdict from the checker's counts
// depends on: tcfq_pkg, tcfq_if, tcfq_checker, two_class_fifo_queue
`timescale 1ns / 1ps

module tb_two_class_fifo_queue;
    import tcfq_pkg::*;

    localparam int         DEPTH       = 16;
    localparam int         PHASES      = 29;
    localparam int         PHASE_ITEMS = 50;
    localparam int         DRAIN       = 20;
    localparam int         CYCLE_LIMIT = 500000;

    logic clk;
    logic rst_n;
    logic calm;
    int   mismatches;
    int   awaited;
    int   cycles;

    tcfq_op_if  op_ch();
    tcfq_res_if res_ch();

    two_class_fifo_queue #(
        .DEPTH   (DEPTH),
        .ID_BITS (IdW)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .op_in   (op_ch),
        .res_out (res_ch)
    );

    tcfq_checker #(
        .DEPTH (DEPTH)
    ) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .op_mon     (op_ch),
        .res_mon    (res_ch),
        .mismatches (mismatches),
        .awaited    (awaited)
    );

    // clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // run limit
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // idle length: mostly none or short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(11, 40);
    endfunction

    // receiver: random stalls, none while calm
    initial
    begin
        int stall;
        stall        = 0;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    stall = gap_len();
            end
        end
    end

    // offer one item from a falling edge and return at the falling edge after acceptance
    task automatic send_item(input logic [1:0] op, input logic cls, input logic [IdW-1:0] id);
        int idle;
        idle = calm ? 0 : gap_len();
        if (idle > 0)
        begin
            op_ch.valid <= 1'b0;
            repeat (idle) @(negedge clk);
        end
        op_ch.valid       <= 1'b1;
        op_ch.operation   <= op;
        op_ch.entry_class <= cls;
        op_ch.entry_id    <= id;
        @(posedge clk);
        while (!op_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // stimulus and verdict
    initial
    begin
        int          enq_pct;
        int          class_mode;
        int          r;
        logic [1:0]  op;
        logic        cls;
        logic [IdW-1:0] id;
        op_ch.valid       = 1'b0;
        op_ch.operation   = OP_ENQUEUE;
        op_ch.entry_class = 1'b0;
        op_ch.entry_id    = '0;
        calm              = 1'b0;
        rst_n             = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty queue, unused code
        send_item(OP_DEQ_ANY, 1'b0, '0);
        send_item(OP_DEQ_CLASS, 1'b0, '0);
        send_item(OP_DEQ_CLASS, 1'b1, '1);
        send_item(OP_UNUSED, 1'b1, '1);
        // extreme ids, interleaved classes
        send_item(OP_ENQUEUE, 1'b0, '0);
        send_item(OP_ENQUEUE, 1'b1, '1);
        send_item(OP_ENQUEUE, 1'b0, 16'h5A5A);
        send_item(OP_ENQUEUE, 1'b1, 16'hA5A5);
        // class dequeue must take the front of its class, not the second
        send_item(OP_DEQ_CLASS, 1'b1, '0);
        send_item(OP_UNUSED, 1'b0, '0);
        send_item(OP_DEQ_ANY, 1'b1, '1);
        send_item(OP_DEQ_ANY, 1'b0, '0);
        send_item(OP_DEQ_CLASS, 1'b0, '0);
        send_item(OP_DEQ_ANY, 1'b0, '0);
        send_item(OP_DEQ_ANY, 1'b1, '0);

        // random phases with a varying balance of enqueue and dequeue
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case ($urandom_range(0, 4))
                0: enq_pct = 90;
                1: enq_pct = 70;
                2: enq_pct = 50;
                3: enq_pct = 30;
                default: enq_pct = 15;
            endcase
            class_mode = $urandom_range(0, 3);
            calm       = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    op = OP_UNUSED;
                else if ($urandom_range(0, 99) < enq_pct)
                    op = OP_ENQUEUE;
                else if ($urandom_range(0, 1) == 0)
                    op = OP_DEQ_ANY;
                else
                    op = OP_DEQ_CLASS;
                case (class_mode)
                    0: cls = 1'b0;
                    1: cls = 1'b1;
                    default: cls = 1'($urandom_range(0, 1));
                endcase
                if ($urandom_range(0, 9) == 0)
                    id = $urandom_range(0, 1) ? '1 : '0;
                else
                    id = IdW'($urandom);
                send_item(op, cls, id);
            end
            // hold off until the block has answered everything
            if (phase % 8 == 4)
            begin
                op_ch.valid <= 1'b0;
                wait (awaited == 0);
                @(negedge clk);
            end
        end

        // drain
        op_ch.valid <= 1'b0;
        calm = 1'b0;
        wait (awaited == 0);
        repeat (DRAIN) @(posedge clk);
        if (mismatches == 0 && awaited == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
